[design/ter_pkg.sv]
// shared types and codes for the threshold edge reachability block
`default_nettype none
package ter_pkg;
	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  first_vertex;
		logic [7:0]  second_vertex;
		logic [15:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic reachable;
		logic edges_dropped;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_POP,
		ST_POPW,
		ST_SCAN,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

[design/threshold_edge_reachability.sv]
// top level: edge table, depth-first reachability walk, result register
//
// channel  dir  payload     handshake
// in       in   in_item_t   in_valid / in_stall
// out      out  out_item_t  out_valid / out_stall
//
// clear and add are applied when accepted; func 3 is accepted and dropped
// a query clears all MAX_VERTICES entries of the visited memory, then for each
// popped vertex other than the target scans the edge table through the edge
// memory read port, one edge a cycle; the visited check adds two pipeline stages
// arst_n resets control state only; edge, stack and visited memories are not
// cleared, the visited memory is rewritten by the clearing pass of every query
// the input stalls while a query runs, and while a held result meets out_stall
`default_nettype none
module threshold_edge_reachability import ter_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 1024,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);
	localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CB = $clog2(MAX_EDGES + 1);
	localparam int SB = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VB + WEIGHT_BITS;

	// edge memory: endpoints and weight in one word
	logic [AW-1:0] edge_mem [MAX_EDGES];
	logic [VB-1:0] stack_mem [MAX_VERTICES];
	// visited map, one bit per vertex
	logic          vis_mem [MAX_VERTICES];

	state_t state_q, state_d;
	logic [CB-1:0] count_q;
	logic          ovf_q;
	logic [SB-1:0] sp_q;
	logic [VB-1:0] clr_q;
	logic [CB-1:0] eidx_q;
	logic [VB-1:0] cur_q, tgt_q;
	logic [WEIGHT_BITS-1:0] minw_q;
	logic          found_q;
	logic [AW-1:0] erd_s1;
	logic          erd_vld_s1;
	logic [VB-1:0] srd_s1;
	logic          cand_s2;
	logic [VB-1:0] nb_s2;
	logic          vis_s2;
	logic          push_q;
	logic [VB-1:0] push_nb_q;
	logic          res_q;

	logic accept;
	logic [WEIGHT_BITS-1:0] w_in;
	logic a_ok, b_ok;
	logic [VB-1:0] ea, eb, nb;
	logic [WEIGHT_BITS-1:0] ew;
	logic cand;
	logic push;
	logic e_read;
	logic [EB-1:0] e_addr;

	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;
	assign w_in     = WEIGHT_BITS'(in_item.weight_value);
	assign a_ok     = 32'(in_item.first_vertex) < MAX_VERTICES;
	assign b_ok     = 32'(in_item.second_vertex) < MAX_VERTICES;
	assign {ea, eb, ew} = erd_s1;

	// stage 1: neighbor of the current vertex over a usable edge, if any
	always_comb begin
		cand = 1'b0;
		nb   = eb;
		if (erd_vld_s1 && ew >= minw_q) begin
			if (ea == cur_q) begin
				cand = 1'b1;
				nb   = eb;
			end else if (eb == cur_q) begin
				cand = 1'b1;
				nb   = ea;
			end
		end
	end

	// stage 2: push when not visited; a push in the previous cycle to the same
	// vertex is not yet in the visited data read for this edge
	assign push = cand_s2 && !vis_s2 && !(push_q && push_nb_q == nb_s2);

	// the target vertex is never expanded
	assign e_read = (state_q == ST_SCAN) && (eidx_q < count_q) && (cur_q != tgt_q);
	assign e_addr = eidx_q[EB-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && in_item.func == FUNC_QUERY && a_ok && b_ok)
				state_d = ST_CLR;
			ST_CLR:  if (32'(clr_q) == MAX_VERTICES - 1) state_d = ST_POP;
			ST_POP: begin
				if (sp_q == '0) state_d = ST_DONE;
				else state_d = ST_POPW;
			end
			ST_POPW: state_d = ST_SCAN;
			ST_SCAN: begin
				// scan ends after the last read has passed both stages
				if (!e_read && !erd_vld_s1 && !cand_s2) state_d = ST_POP;
			end
			// hold the answer until the result register is free
			ST_DONE: if (!(out_valid && out_stall)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.func == FUNC_ADD && a_ok && b_ok && count_q < CB'(MAX_EDGES))
			edge_mem[count_q[EB-1:0]] <= {VB'(in_item.first_vertex),
				VB'(in_item.second_vertex), w_in};
		if (e_read) erd_s1 <= edge_mem[e_addr];
		// clearing pass marks only the start vertex
		if (state_q == ST_CLR) vis_mem[clr_q] <= (clr_q == cur_q);
		else if (push) vis_mem[nb_s2] <= 1'b1;
		if (erd_vld_s1) vis_s2 <= vis_mem[nb];
		if (push && 32'(sp_q) < MAX_VERTICES) stack_mem[sp_q[VB-1:0]] <= nb_s2;
		else if (state_q == ST_CLR && 32'(clr_q) == MAX_VERTICES - 1)
			stack_mem[0] <= cur_q;
		if (state_q == ST_POP && sp_q != '0) srd_s1 <= stack_mem[VB'(sp_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			sp_q       <= '0;
			clr_q      <= '0;
			eidx_q     <= '0;
			cur_q      <= '0;
			tgt_q      <= '0;
			minw_q     <= '0;
			found_q    <= 1'b0;
			erd_vld_s1 <= 1'b0;
			cand_s2    <= 1'b0;
			nb_s2      <= '0;
			push_q     <= 1'b0;
			push_nb_q  <= '0;
			out_valid  <= 1'b0;
			out_item   <= '0;
		end else begin
			erd_vld_s1 <= e_read;
			cand_s2    <= cand;
			nb_s2      <= nb;
			push_q     <= push;
			push_nb_q  <= nb_s2;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					case (in_item.func)
						FUNC_CLEAR: begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
						FUNC_ADD: if (a_ok && b_ok) begin
							if (count_q < CB'(MAX_EDGES)) count_q <= count_q + 1'b1;
							else ovf_q <= 1'b1;
						end
						FUNC_QUERY: begin
							if (a_ok && b_ok) begin
								cur_q   <= VB'(in_item.first_vertex);
								tgt_q   <= VB'(in_item.second_vertex);
								minw_q  <= w_in;
								clr_q   <= '0;
								found_q <= (in_item.first_vertex == in_item.second_vertex);
							end else begin
								out_valid <= 1'b1;
								out_item  <= '{reachable: 1'b0, edges_dropped: ovf_q};
							end
						end
						default: ;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_VERTICES - 1) sp_q <= SB'(1);
				end
				ST_POP: if (sp_q != '0) sp_q <= sp_q - 1'b1;
				ST_POPW: begin
					cur_q  <= srd_s1;
					eidx_q <= '0;
				end
				ST_SCAN: begin
					if (e_read) eidx_q <= eidx_q + 1'b1;
					if (push) begin
						if (nb_s2 == tgt_q) found_q <= 1'b1;
						if (32'(sp_q) < MAX_VERTICES) sp_q <= sp_q + 1'b1;
					end
				end
				ST_DONE: if (!(out_valid && out_stall)) begin
					out_valid <= 1'b1;
					out_item  <= '{reachable: found_q, edges_dropped: ovf_q};
				end
				default: ;
			endcase
		end
	end

	// res_q mirrors the last reachability answer for checking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_q <= 1'b0;
		else if (state_q == ST_DONE && !(out_valid && out_stall)) res_q <= found_q;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(MAX_EDGES)) else $error("edge count overrun");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !(out_valid && out_stall)) |=>
		(out_valid && out_item.reachable == res_q))
		else $error("query result lost");
endmodule
`default_nettype wire

[tb/sv/threshold_edge_reachability_test.sv]
// testbench for the threshold edge reachability block
`timescale 1ns / 1ps
module threshold_edge_reachability_test;
	import ter_pkg::*;

	localparam int NUM_VERTICES = 256;
	localparam int TABLE_DEPTH  = 1024;
	localparam int RANDOM_ITEMS = 110;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 600;

	// predicts reachability answers and keeps the expected answers in order
	class reach_scoreboard;
		logic [7:0]  end_a [TABLE_DEPTH];
		logic [7:0]  end_b [TABLE_DEPTH];
		logic [15:0] wgt [TABLE_DEPTH];
		int unsigned edge_total;
		bit          dropped;
		out_item_t   answers [$];
		int          mismatches;
		int          queries;
		int          reached;
		int          drop_reports;

		function new();
			edge_total = 0;
			dropped = 0;
			mismatches = 0;
			queries = 0;
			reached = 0;
			drop_reports = 0;
		endfunction

		// depth-first walk over edges whose weight meets the minimum
		function bit walk(int start, int target, logic [15:0] minw);
			bit seen [NUM_VERTICES];
			int stack [$];
			int v;
			foreach (seen[i])
				seen[i] = 0;
			seen[start] = 1;
			stack.push_back(start);
			while (stack.size() > 0) begin
				v = stack.pop_back();
				if (v == target)
					continue;
				for (int e = 0; e < edge_total; e++) begin
					if (wgt[e] < minw)
						continue;
					if (end_a[e] == v && !seen[end_b[e]]) begin
						seen[end_b[e]] = 1;
						stack.push_back(int'(end_b[e]));
					end else if (end_a[e] != v && end_b[e] == v && !seen[end_a[e]]) begin
						seen[end_a[e]] = 1;
						stack.push_back(int'(end_a[e]));
					end
				end
			end
			return seen[target];
		endfunction

		function void note_input(in_item_t it);
			out_item_t ans;
			case (it.func)
				FUNC_CLEAR: begin
					edge_total = 0;
					dropped = 0;
				end
				FUNC_ADD: begin
					// 8-bit endpoints are always in range
					if (edge_total >= TABLE_DEPTH) begin
						dropped = 1;
					end else begin
						end_a[edge_total] = it.first_vertex;
						end_b[edge_total] = it.second_vertex;
						wgt[edge_total] = it.weight_value;
						edge_total++;
					end
				end
				FUNC_QUERY: begin
					ans.reachable = walk(int'(it.first_vertex), int'(it.second_vertex),
						it.weight_value);
					ans.edges_dropped = dropped;
					answers.push_back(ans);
					queries++;
					reached += ans.reachable;
					drop_reports += ans.edges_dropped;
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check(out_item_t got);
			out_item_t want;
			if (answers.size() == 0) begin
				report($sformatf("answer %b/%b with none expected",
					got.reachable, got.edges_dropped));
			end else begin
				want = answers.pop_front();
				if (got.reachable !== want.reachable)
					report($sformatf("reachable %b, expected %b",
						got.reachable, want.reachable));
				if (got.edges_dropped !== want.edges_dropped)
					report($sformatf("edges_dropped %b, expected %b",
						got.edges_dropped, want.edges_dropped));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	reach_scoreboard sb;
	int  cycles;
	bit  no_idle;      // both sides run without gaps while set
	bit  hold_request; // asks the receiver for one long hold-off
	int  hold_left;
	int  recv_wait;
	int  sent;

	threshold_edge_reachability uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		clk = 0;
		#10;
		clk = 1;
		#10;
	end

	// cycle counter doubles as the watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding",
				cycles, sb.answers.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: check every transfer, then draw the next wait
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check(out_item);
			recv_wait = no_idle ? 0 : $urandom_range(0, 3);
		end
	end

	// stall is driven at the falling edge; the long hold-off counts down here
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall = 1;
			hold_left--;
		end else if (recv_wait > 0) begin
			out_stall = 1;
			recv_wait--;
		end else begin
			out_stall = 0;
		end
	end

	// offer one item, wait out the transfer, then record it
	task send(in_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_item = it;
		in_valid = 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
		sent++;
		@(negedge clk);
	endtask

	task send_fields(func_t f, int a, int b, int w);
		in_item_t it;
		it.func = f;
		it.first_vertex = 8'(a);
		it.second_vertex = 8'(b);
		it.weight_value = 16'(w);
		send(it);
	endtask

	// sender pause until every expected answer is back
	task drain();
		in_valid = 0;
		while (sb.answers.size() > 0)
			@(negedge clk);
	endtask

	// mostly small vertex numbers so the walks find paths, sometimes any
	function int pick_vertex();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
	endfunction

	function in_item_t random_item();
		in_item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			it.func = FUNC_CLEAR;
		else if (roll < 52)
			it.func = FUNC_ADD;
		else if (roll < 95)
			it.func = FUNC_QUERY;
		else
			it.func = FUNC_NONE;
		it.first_vertex = 8'(pick_vertex());
		it.second_vertex = 8'(pick_vertex());
		it.weight_value = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		sent = 0;
		no_idle = 0;
		hold_request = 0;
		hold_left = 0;
		recv_wait = 0;
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty graph, both weight extremes, self loop, top vertices
		send_fields(FUNC_QUERY, 255, 255, 16'hFFFF);
		send_fields(FUNC_QUERY, 0, 1, 0);
		send_fields(FUNC_ADD, 0, 1, 16'hFFFF);
		send_fields(FUNC_ADD, 1, 2, 0);
		send_fields(FUNC_ADD, 255, 254, 16'h8000);
		send_fields(FUNC_ADD, 3, 3, 16'h5555);
		send_fields(FUNC_QUERY, 0, 2, 0);
		send_fields(FUNC_QUERY, 0, 2, 1);
		send_fields(FUNC_QUERY, 2, 0, 0);
		send_fields(FUNC_QUERY, 0, 1, 16'hFFFF);
		send_fields(FUNC_QUERY, 254, 255, 16'h8000);
		send_fields(FUNC_QUERY, 254, 255, 16'h8001);
		send_fields(FUNC_QUERY, 3, 4, 0);
		send_fields(FUNC_QUERY, 3, 3, 16'hFFFF);
		// unused code must leave the table alone
		send_fields(FUNC_NONE, 8'hAA, 8'h55, 16'hAAAA);
		send_fields(FUNC_QUERY, 0, 2, 0);
		send_fields(FUNC_CLEAR, 0, 0, 0);
		send_fields(FUNC_QUERY, 0, 1, 0);

		// a gapless run of adds on a few vertices, some queries, then clear and query again
		no_idle = 1;
		for (int i = 0; i < 8; i++)
			send_fields(FUNC_ADD, $urandom_range(0, 7), $urandom_range(0, 7),
				$urandom_range(0, 65535));
		send_fields(FUNC_QUERY, 0, 7, 16'h4000);
		send_fields(FUNC_ADD, 8, 9, 0);
		send_fields(FUNC_ADD, 0, 9, 0);
		no_idle = 0;
		send_fields(FUNC_QUERY, 0, 9, 0);
		send_fields(FUNC_QUERY, 5, 6, 16'hC000);
		send_fields(FUNC_CLEAR, 0, 0, 0);
		send_fields(FUNC_QUERY, 0, 7, 0);
		drain();

		// random: gapless stretch, a long receiver hold-off, a full drain
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 20 && i < 35);
			if (i == 45)
				hold_request = 1;
			if (i == 95)
				drain();
			send(random_item());
		end
		in_valid = 0;

		while (sb.answers.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("sent %0d items in %0d cycles: %0d queries, %0d reachable, %0d with drop flag",
			sent, cycles, sb.queries, sb.reached, sb.drop_reports);
		$display("covered clears, unused code, gapless runs and a long receiver hold-off");
		if (sb.mismatches == 0 && sb.answers.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

[sim.f]
design/ter_pkg.sv
design/threshold_edge_reachability.sv
tb/sv/threshold_edge_reachability_test.sv
